// File: hw/rtl/keyed_slot_table_macros.svh
// Assertion macros used by the checker of the slot table.
`ifndef KEYED_SLOT_TABLE_MACROS_SVH
`define KEYED_SLOT_TABLE_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define KST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keyed_slot_table check failed");

// Next-cycle implication, active during reset as well.
`define KST_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("keyed_slot_table check failed");

`endif

// File: hw/rtl/kst_pkg.sv
package kst_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SLOT_W      = 6;
    localparam int KEY_W       = 16;
    localparam int DATA_W      = 48;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // Request codes on the input port
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  assigned_key;
        logic [DATA_W-1:0] record_data;
    } t_res;

    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } t_entry;

    // Slot index reported modulo 2**SLOT_W
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/kst_queue.sv
module kst_queue
    import kst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd            r_buf [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == QC_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_buf[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/kst_front.sv
module kst_front
    import kst_pkg::*;
(
    input  logic start,
    output logic busy,
    input  t_req i_req,
    input  logic i_q_full,
    output logic o_push,
    output t_cmd o_push_cmd
);

    t_op w_op;

    // Classify the request code
    always_comb begin
        unique case (i_req.req_type)
            REQ_INSERT: w_op = OP_INSERT;
            REQ_LOOKUP: w_op = OP_LOOKUP;
            REQ_REMOVE: w_op = OP_REMOVE;
            default:    w_op = OP_NOP;
        endcase
    end

    // Accept whenever the queue has room
    assign busy               = i_q_full;
    assign o_push             = start && !i_q_full;
    assign o_push_cmd.op      = w_op;
    assign o_push_cmd.key     = i_req.key;
    assign o_push_cmd.payload = i_req.payload;

endmodule

// File: hw/rtl/kst_back.sv
module kst_back
    import kst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [KEY_W-1:0] i_cfg_wdata,
    input  logic             i_q_empty,
    input  t_cmd             i_q_head,
    output logic             o_q_pop,
    output logic             o_res_valid,
    output t_res             o_res
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_state             r_state;
    t_cmd               r_cmd;
    logic [KEY_W-1:0]   r_next_key;
    logic [TABLE_DEPTH-1:0] r_valid;
    t_entry             r_mem [TABLE_DEPTH];

    // Scan issue stage
    logic               r_issue;
    logic [IDX_W-1:0]   r_idx;
    // Scan compare stage
    t_entry             r_entry;
    logic               r_p_live;
    logic               r_p_free;
    logic               r_p_last;
    logic [IDX_W-1:0]   r_p_idx;

    t_res               r_res;
    logic               r_res_valid;

    // Next values of the sequencer registers
    t_state             n_state;
    logic               n_issue;
    logic [IDX_W-1:0]   n_idx;
    logic               n_p_live;
    logic [TABLE_DEPTH-1:0] n_valid;
    logic [KEY_W-1:0]   n_next_key;
    logic               n_res_valid;
    t_res               n_res;

    logic               w_hit;
    logic               w_wr;

    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    // Hit test on the slot from the registered read
    always_comb begin
        if (r_cmd.op == OP_INSERT) begin
            w_hit = r_p_free;
        end else begin
            w_hit = !r_p_free && (r_entry.key == r_cmd.key);
        end
        w_hit = w_hit && r_p_live && (r_state == S_SCAN);
    end

    assign w_wr = w_hit && (r_cmd.op == OP_INSERT);

    // Record memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_p_idx] <= '{key: r_next_key, data: r_cmd.payload};
        end
        r_entry <= r_mem[r_idx];
    end

    // Command register and compare-stage payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_head;
        end
        r_p_free <= !r_valid[r_idx];
        r_p_idx  <= r_idx;
        r_p_last <= (r_idx == LAST_IDX);
    end

    // Sequencer, valid marks, key counter and result: next values
    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_idx       = r_idx;
        n_p_live    = r_p_live;
        n_valid     = r_valid;
        n_next_key  = r_next_key;
        n_res_valid = 1'b0;
        n_res       = r_res;

        if (i_cfg_we) begin
            n_next_key = i_cfg_wdata;
        end else if (w_wr) begin
            n_next_key = r_next_key + 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                n_p_live = 1'b0;
                if (o_q_pop) begin
                    if (i_q_head.op == OP_NOP) begin
                        n_res_valid = 1'b1;
                        n_res       = '{status: ST_NOT_FOUND, default: '0};
                    end else begin
                        n_idx   = '0;
                        n_issue = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue stage walks the slots in order
                n_p_live = r_issue;
                if (r_issue) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end
                end
                // compare stage decides the transaction
                if (w_hit) begin
                    n_issue     = 1'b0;
                    n_p_live    = 1'b0;
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                    n_res       = '{status: ST_DONE, default: '0};
                    n_res.slot  = to_slot(r_p_idx);
                    case (r_cmd.op)
                        OP_INSERT: begin
                            n_valid[r_p_idx]   = 1'b1;
                            n_res.assigned_key = r_next_key;
                        end
                        OP_LOOKUP: begin
                            n_res.record_data = r_entry.data;
                        end
                        default: begin
                            n_valid[r_p_idx] = 1'b0;
                        end
                    endcase
                end else if (r_p_live && r_p_last) begin
                    n_p_live    = 1'b0;
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                    if (r_cmd.op == OP_INSERT) begin
                        n_res = '{status: ST_FULL, default: '0};
                    end else begin
                        n_res = '{status: ST_NOT_FOUND, default: '0};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer, valid marks, key counter and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_idx       <= '0;
            r_p_live    <= 1'b0;
            r_valid     <= '0;
            r_next_key  <= '0;
            r_res_valid <= 1'b0;
            r_res       <= '{status: ST_DONE, default: '0};
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_idx       <= n_idx;
            r_p_live    <= n_p_live;
            r_valid     <= n_valid;
            r_next_key  <= n_next_key;
            r_res_valid <= n_res_valid;
            r_res       <= n_res;
        end
    end

endmodule

// File: hw/rtl/keyed_slot_table.sv
// Table of TABLE_DEPTH record slots with insert (lowest free slot, key from a
// 16-bit counter loaded by i_cfg_wdata), lookup and remove by key. A request is
// taken when start is high and busy is low; a two-entry command queue lets
// requests be taken while the table engine works. Each request yields exactly
// one result, shown for a single cycle with o_res_valid high; the receiver
// cannot stall it. The engine reads one slot per cycle from the record memory.
// It pops a command from the queue only while idle, registers it, walks the
// slots through its issue and compare stages and registers the result: insert
// ends at the first free slot, lookup and remove at the first matching key,
// misses and full inserts walk the whole table, and an unused request code
// gets a not-found result without a scan. Time spent waiting in the queue
// delays the result. Slots are empty after reset; no clearing pass is needed.
module keyed_slot_table
    import kst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [KEY_W-1:0] i_cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_res_valid,
    output t_res             o_res
);

    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;
    t_cmd w_q_head;

    kst_front u_front (
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_push_cmd (w_push_cmd)
    );

    kst_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_q_full),
        .i_pop      (w_q_pop),
        .o_empty    (w_q_empty),
        .o_head     (w_q_head)
    );

    kst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (w_q_empty),
        .i_q_head    (w_q_head),
        .o_q_pop     (w_q_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

// File: hw/rtl/kst_chk.sv
`include "keyed_slot_table_macros.svh"

module kst_chk
    import kst_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_res_valid,
    input t_res o_res
);

    logic w_full_res;
    logic w_miss_res;
    logic w_key_res;
    logic w_res_empty;

    // Result classes seen on the ports
    assign w_full_res  = o_res_valid && (o_res.status == ST_FULL);
    assign w_miss_res  = o_res_valid && (o_res.status == ST_NOT_FOUND);
    assign w_key_res   = o_res_valid && (o_res.assigned_key != '0);
    assign w_res_empty = (o_res.slot == '0) && (o_res.assigned_key == '0)
                         && (o_res.record_data == '0);

    // No result right after reset
    `KST_ASSERT_NEXT(a_no_res_after_reset, i_clk, !i_rst_n, !o_res_valid)

    // A full table reports no slot, key or data
    `KST_ASSERT_NOW(a_full_zero, i_clk, i_rst_n, w_full_res, w_res_empty)

    // A miss reports no slot, key or data
    `KST_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, w_miss_res, w_res_empty)

    // Insert and lookup results never carry both a key and data
    `KST_ASSERT_NOW(a_key_or_data, i_clk, i_rst_n, w_key_res, o_res.record_data == '0)

endmodule

bind keyed_slot_table kst_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
